// ===== rtl/core/pti_pkg.sv =====
package pti_pkg;

  localparam int NUM_JOINTS          = 4;
  localparam int DEFAULT_MAX_POINTS  = 64;
  localparam int DEFAULT_JOINT_COUNT = 4;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_COMMIT = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  localparam logic [1:0] REGION_START  = 2'd0;
  localparam logic [1:0] REGION_INTERP = 2'd1;
  localparam logic [1:0] REGION_LAST   = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         point_index;
    logic [31:0]        point_offset;
    logic signed [31:0] point_joint0;
    logic signed [31:0] point_joint1;
    logic signed [31:0] point_joint2;
    logic signed [31:0] point_joint3;
    logic               last_point;
    logic [31:0]        event_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_joint0;
    logic signed [31:0] out_joint1;
    logic signed [31:0] out_joint2;
    logic signed [31:0] out_joint3;
    logic [1:0]         region;
  } out_item_t;

  typedef struct packed {
    logic        en;
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_wr_t;

  typedef enum logic [2:0] {
    RD_HOLD,
    RD_LAST,
    RD_ZERO,
    RD_NEXT,
    RD_PREV
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_LAST,
    S_SCAN,
    S_PREV,
    S_START,
    S_ARITH,
    S_FINISH,
    S_COPY,
    S_CEND
  } state_t;

  typedef struct packed {
    logic    latch;
    logic    cap_dt;
    rd_sel_t rd_sel;
    logic    hold_start;
    logic    hold_last;
    logic    take_t1;
    logic    take_t0;
    logic    arith_start;
    logic    take_arith;
    logic    emit;
    logic    commit_start;
    logic    copy_step;
    logic    commit_fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic early;
    logic below;
    logic idx_zero;
    logic arith_done;
    logic copy_last;
    logic out_free;
    logic is_query;
  } ctl_sts_t;

endpackage

// ===== rtl/core/pti_lerp.sv =====
module pti_lerp (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] p0,
  input  logic signed [31:0] p1,
  input  logic [31:0]        num,
  input  logic [31:0]        span,
  output logic               done,
  output logic signed [31:0] res
);

  logic        busy;
  logic        phase;
  logic [4:0]  cnt;
  logic        neg;
  logic [31:0] mag;
  logic [31:0] hi;
  logic [31:0] lo;
  logic [31:0] span_r;
  logic [31:0] p0_r;

  logic [32:0] d;
  logic [32:0] dneg;
  logic [32:0] msum;
  logic [32:0] shl;
  logic [32:0] diff;
  logic        geq;

  assign d    = {p1[31], p1} - {p0[31], p0};
  assign dneg = 33'd0 - d;
  assign msum = {1'b0, hi} + {1'b0, mag};
  assign shl  = {hi, lo[31]};
  assign diff = shl - {1'b0, span_r};
  assign geq  = shl >= {1'b0, span_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (&cnt) begin
          if (phase) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            phase <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg    <= d[32];
      mag    <= d[32] ? dneg[31:0] : d[31:0];
      hi     <= '0;
      lo     <= num;
      span_r <= span;
      p0_r   <= p0;
    end else if (busy) begin
      if (!phase) begin
        if (lo[0]) begin
          hi <= msum[32:1];
          lo <= {msum[0], lo[31:1]};
        end else begin
          hi <= {1'b0, hi[31:1]};
          lo <= {hi[0], lo[31:1]};
        end
      end else begin
        hi <= geq ? diff[31:0] : shl[31:0];
        lo <= {lo[30:0], geq};
      end
    end
  end

  assign res = neg ? $signed(p0_r - lo) : $signed(p0_r + lo);

endmodule

// ===== rtl/core/pti_datapath.sv =====
module pti_datapath #(
  parameter int MAX_POINTS  = pti_pkg::DEFAULT_MAX_POINTS,
  parameter int JOINT_COUNT = pti_pkg::DEFAULT_JOINT_COUNT
) (
  input  logic                clk,
  input  logic                rst,
  input  pti_pkg::in_item_t   item,
  input  pti_pkg::cfg_wr_t    cfg_wr,
  input  pti_pkg::ctl_cmd_t   cmd,
  output pti_pkg::ctl_sts_t   sts,
  output logic                result_valid,
  input  logic                result_ready,
  output pti_pkg::out_item_t  result
);

  import pti_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = 32 * JOINT_COUNT;

  logic [31:0]   sh_t [MAX_POINTS];
  logic [PW-1:0] sh_p [MAX_POINTS];
  logic [31:0]   ac_t [MAX_POINTS];
  logic [PW-1:0] ac_p [MAX_POINTS];

  logic [31:0]   srd_t;
  logic [PW-1:0] srd_p;
  logic [31:0]   tr;
  logic [PW-1:0] pr;

  logic [1:0]    q_mode;
  logic [31:0]   q_etime;
  logic [31:0]   start_time;
  logic [31:0]   dt;
  logic [CW-1:0] active_count;
  logic [CW-1:0] shadow_count;
  logic [AW-1:0] idx;
  logic [AW-1:0] raddr;
  logic [AW-1:0] ccnt;
  logic          cwr;
  logic [AW-1:0] cwaddr;
  logic [31:0]   t0;
  logic [31:0]   t1;
  logic [1:0]    res_region;

  logic signed [31:0] start_pos [JOINT_COUNT];
  logic signed [31:0] p0        [JOINT_COUNT];
  logic signed [31:0] p1        [JOINT_COUNT];
  logic signed [31:0] res_pos   [JOINT_COUNT];
  logic signed [31:0] lane_res  [JOINT_COUNT];
  logic [JOINT_COUNT-1:0] lane_done;

  logic signed [31:0] in_joint  [NUM_JOINTS];
  logic signed [31:0] out_joint [NUM_JOINTS];
  logic [PW-1:0]      in_row;
  logic               load_wr;

  assign in_joint[0] = item.point_joint0;
  assign in_joint[1] = item.point_joint1;
  assign in_joint[2] = item.point_joint2;
  assign in_joint[3] = item.point_joint3;

  for (genvar j = 0; j < JOINT_COUNT; j++) begin : g_row
    assign in_row[j*32 +: 32] = in_joint[j];
  end

  assign load_wr = cmd.latch && (item.mode == MODE_LOAD)
                   && (32'(item.point_index) < MAX_POINTS);

  always_ff @(posedge clk) begin
    if (load_wr) begin
      sh_t[AW'(item.point_index)] <= item.point_offset;
      sh_p[AW'(item.point_index)] <= in_row;
    end
    srd_t <= sh_t[ccnt];
    srd_p <= sh_p[ccnt];
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_LAST: raddr = AW'(active_count - CW'(1));
      RD_ZERO: raddr = '0;
      RD_NEXT: raddr = idx + AW'(1);
      RD_PREV: raddr = idx - AW'(1);
      default: raddr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cwr) begin
      ac_t[cwaddr] <= srd_t;
      ac_p[cwaddr] <= srd_p;
    end
    tr <= ac_t[raddr];
    pr <= ac_p[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= '0;
      shadow_count <= '0;
      start_time   <= '0;
      cwr          <= 1'b0;
      ccnt         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load_wr && item.last_point) begin
        shadow_count <= CW'(item.point_index) + CW'(1);
      end
      if (cmd.commit_start) begin
        start_time <= q_etime;
      end
      if (cmd.commit_fin) begin
        active_count <= shadow_count;
      end
      cwr <= cmd.copy_step;
      if (cmd.commit_start) begin
        ccnt <= '0;
      end else if (cmd.copy_step) begin
        ccnt <= ccnt + AW'(1);
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cwaddr <= ccnt;
    if (cmd.latch) begin
      q_mode  <= item.mode;
      q_etime <= item.event_time;
    end
    if (cmd.cap_dt) begin
      dt <= q_etime - start_time;
    end
    if (cmd.rd_sel == RD_ZERO) begin
      idx <= '0;
    end else if (cmd.rd_sel == RD_NEXT) begin
      idx <= idx + AW'(1);
    end
    if (cmd.take_t1) begin
      t1 <= tr;
    end
    if (cmd.take_t0) begin
      t0 <= (idx == '0) ? 32'd0 : tr;
    end
    if (cmd.hold_start) begin
      res_region <= REGION_START;
    end else if (cmd.hold_last) begin
      res_region <= REGION_LAST;
    end else if (cmd.take_arith) begin
      res_region <= REGION_INTERP;
    end
  end

  for (genvar j = 0; j < JOINT_COUNT; j++) begin : g_lane
    always_ff @(posedge clk) begin
      if (rst) begin
        start_pos[j] <= '0;
      end else if (cfg_wr.en && (cfg_wr.index == 2'(j))) begin
        start_pos[j] <= cfg_wr.data;
      end else if (cmd.commit_start) begin
        start_pos[j] <= res_pos[j];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.take_t1) begin
        p1[j] <= pr[j*32 +: 32];
      end
      if (cmd.take_t0) begin
        p0[j] <= (idx == '0) ? start_pos[j] : $signed(pr[j*32 +: 32]);
      end
      if (cmd.hold_start) begin
        res_pos[j] <= start_pos[j];
      end else if (cmd.hold_last) begin
        res_pos[j] <= pr[j*32 +: 32];
      end else if (cmd.take_arith) begin
        res_pos[j] <= lane_res[j];
      end
    end

    pti_lerp u_lerp (
      .clk   (clk),
      .rst   (rst),
      .start (cmd.arith_start),
      .p0    (p0[j]),
      .p1    (p1[j]),
      .num   (dt - t0),
      .span  (t1 - t0),
      .done  (lane_done[j]),
      .res   (lane_res[j])
    );
  end

  for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_out
    if (j < JOINT_COUNT) begin : g_used
      assign out_joint[j] = res_pos[j];
    end else begin : g_zero
      assign out_joint[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.out_joint0 <= out_joint[0];
      result.out_joint1 <= out_joint[1];
      result.out_joint2 <= out_joint[2];
      result.out_joint3 <= out_joint[3];
      result.region     <= res_region;
    end
  end

  assign sts.early      = (q_etime < start_time) || (active_count == '0);
  assign sts.below      = dt < tr;
  assign sts.idx_zero   = (idx == '0);
  assign sts.arith_done = lane_done[0];
  assign sts.copy_last  = (ccnt == AW'(MAX_POINTS - 1));
  assign sts.out_free   = !result_valid || result_ready;
  assign sts.is_query   = (q_mode == MODE_QUERY);

  a_emit_free : assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!result_valid || result_ready))
    else $error("result overwritten before transfer");

  a_emit_query : assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (q_mode == MODE_QUERY))
    else $error("result issued for an item other than a query");

  a_copy_end : assert property (@(posedge clk) disable iff (rst)
    cmd.commit_fin |-> (cwr && (cwaddr == AW'(MAX_POINTS - 1))))
    else $error("table copy finished before the last entry");

endmodule

// ===== rtl/core/pti_ctrl.sv =====
module pti_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic [1:0]         item_mode,
  output logic               item_ready,
  output pti_pkg::ctl_cmd_t  cmd,
  input  pti_pkg::ctl_sts_t  sts
);

  import pti_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_HOLD;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.latch = 1'b1;
          if ((item_mode == MODE_COMMIT) || (item_mode == MODE_QUERY)) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd.cap_dt = 1'b1;
        if (sts.early) begin
          cmd.hold_start = 1'b1;
          state_next     = S_FINISH;
        end else begin
          cmd.rd_sel = RD_LAST;
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        if (!sts.below) begin
          cmd.hold_last = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.rd_sel = RD_ZERO;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.below) begin
          cmd.take_t1 = 1'b1;
          cmd.rd_sel  = RD_PREV;
          state_next  = S_PREV;
        end else begin
          cmd.rd_sel = RD_NEXT;
        end
      end
      S_PREV: begin
        cmd.take_t0 = 1'b1;
        state_next  = S_START;
      end
      S_START: begin
        cmd.arith_start = 1'b1;
        state_next      = S_ARITH;
      end
      S_ARITH: begin
        if (sts.arith_done) begin
          cmd.take_arith = 1'b1;
          state_next     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.is_query) begin
          if (sts.out_free) begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.commit_start = 1'b1;
          state_next       = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_last) begin
          state_next = S_CEND;
        end
      end
      S_CEND: begin
        cmd.commit_fin = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/piecewise_linear_trajectory_interp.sv =====
// Channel   Direction  Handshake                        Payload
// item      in         item_valid / item_ready          in_item_t
// result    out        result_valid / result_ready      out_item_t
// config    in         psel, penable, pwrite, pready    paddr, pwdata -> prdata
//
// A load writes the shadow table and the controller stays idle. A held query answers with the
// start or last position; an interpolated one finds the first later waypoint by a serial search,
// one entry per cycle, then runs the shift-add multiply and restoring divide per lane.
// A commit adds a copy of the table from shadow to active, one entry per cycle.
// Reset is synchronous and clears the counts, start time and start positions.
// A waiting result does not block the next item until another result is ready to leave.
module piecewise_linear_trajectory_interp #(
  parameter int MAX_POINTS  = pti_pkg::DEFAULT_MAX_POINTS,
  parameter int JOINT_COUNT = pti_pkg::DEFAULT_JOINT_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  pti_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output pti_pkg::out_item_t result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import pti_pkg::*;

  logic [31:0] seed [NUM_JOINTS];
  cfg_wr_t     cfg_wr;
  ctl_cmd_t    cmd;
  ctl_sts_t    sts;

  assign pready       = 1'b1;
  assign cfg_wr.en    = psel && penable && pwrite && pready;
  assign cfg_wr.index = paddr[3:2];
  assign cfg_wr.data  = pwdata;

  for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_seed
    if (j < JOINT_COUNT) begin : g_used
      always_ff @(posedge clk) begin
        if (rst) begin
          seed[j] <= '0;
        end else if (cfg_wr.en && (cfg_wr.index == 2'(j))) begin
          seed[j] <= cfg_wr.data;
        end
      end
    end else begin : g_zero
      assign seed[j] = '0;
    end
  end

  assign prdata = seed[paddr[3:2]];

  pti_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_mode  (item.mode),
    .item_ready (item_ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  pti_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .JOINT_COUNT (JOINT_COUNT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_wr       (cfg_wr),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== verif/piecewise_linear_trajectory_interp_tb.sv =====
`timescale 1ns / 1ps

module piecewise_linear_trajectory_interp_tb;
  import pti_pkg::*;

  localparam int NPTS = 64;
  localparam int SETTLE = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  in_item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_item_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  piecewise_linear_trajectory_interp dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Own copy of the interpolator state.
  logic [31:0] shadow_time[NPTS];
  logic signed [31:0] shadow_pos[NPTS][4];
  logic [31:0] active_time[NPTS];
  logic signed [31:0] active_pos[NPTS][4];
  bit slot_written[NPTS];
  int shadow_cnt;
  int active_cnt;
  logic signed [31:0] start_pos[4];
  logic [31:0] start_t;
  logic signed [31:0] seed_val[4];

  out_item_t expected_positions[$];
  int errors = 0;
  int items_sent = 0;
  int queries_checked = 0;
  int commits_sent = 0;
  int loads_sent = 0;
  bit no_gaps = 1'b0;
  bit long_hold = 1'b0;

  function automatic logic signed [31:0] lerp(logic signed [31:0] p0, logic signed [31:0] p1,
                                              logic [31:0] num, logic [31:0] span);
    logic signed [63:0] d;
    logic [63:0] mag;
    logic [63:0] q;
    d = {{32{p1[31]}}, p1} - {{32{p0[31]}}, p0};
    mag = (d < 0) ? -d : d;
    q = (mag * {32'b0, num}) / {32'b0, span};
    return (d < 0) ? p0 - q[31:0] : p0 + q[31:0];
  endfunction

  function automatic out_item_t position_at(logic [31:0] t);
    out_item_t r;
    logic signed [31:0] pos[4];
    logic [31:0] dt;
    logic [31:0] t0;
    int idx;
    idx = 0;
    if (t < start_t || active_cnt == 0) begin
      pos = start_pos;
      r.region = REGION_START;
    end else begin
      dt = t - start_t;
      if (dt >= active_time[active_cnt-1]) begin
        pos = active_pos[active_cnt-1];
        r.region = REGION_LAST;
      end else begin
        for (int i = active_cnt - 1; i >= 0; i--)
          if (dt < active_time[i]) idx = i;
        t0 = (idx == 0) ? 32'd0 : active_time[idx-1];
        for (int j = 0; j < 4; j++)
          pos[j] = lerp((idx == 0) ? start_pos[j] : active_pos[idx-1][j], active_pos[idx][j],
                        dt - t0, active_time[idx] - t0);
        r.region = REGION_INTERP;
      end
    end
    r.out_joint0 = pos[0];
    r.out_joint1 = pos[1];
    r.out_joint2 = pos[2];
    r.out_joint3 = pos[3];
    return r;
  endfunction

  function automatic void predict_transfer(in_item_t x);
    out_item_t r;
    case (x.mode)
      MODE_LOAD: begin
        shadow_time[x.point_index] = x.point_offset;
        shadow_pos[x.point_index] = '{x.point_joint0, x.point_joint1, x.point_joint2,
                                      x.point_joint3};
        slot_written[x.point_index] = 1'b1;
        if (x.last_point) shadow_cnt = int'(x.point_index) + 1;
      end
      MODE_COMMIT: begin
        r = position_at(x.event_time);
        start_pos = '{r.out_joint0, r.out_joint1, r.out_joint2, r.out_joint3};
        start_t = x.event_time;
        active_time = shadow_time;
        active_pos = shadow_pos;
        active_cnt = shadow_cnt;
      end
      MODE_QUERY: expected_positions = {expected_positions, position_at(x.event_time)};
      default: ;
    endcase
  endfunction

  function automatic bit prefix_written(int idx);
    for (int i = 0; i < idx; i++)
      if (!slot_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic in_item_t random_item();
    in_item_t x;
    x.mode = 2'($urandom);
    x.point_index = 6'($urandom);
    x.point_offset = $urandom;
    x.point_joint0 = $urandom;
    x.point_joint1 = $urandom;
    x.point_joint2 = $urandom;
    x.point_joint3 = $urandom;
    x.last_point = 1'($urandom);
    x.event_time = $urandom;
    return x;
  endfunction

  task automatic send_item(in_item_t x);
    int n;
    n = no_gaps ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (n > 0) begin
      item_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    item = x;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    predict_transfer(x);
    items_sent++;
    if (x.mode == MODE_LOAD) loads_sent++;
    if (x.mode == MODE_COMMIT) commits_sent++;
  endtask

  task automatic send_load(int idx, logic [31:0] offset, bit last);
    in_item_t x;
    x = random_item();
    x.mode = MODE_LOAD;
    x.point_index = 6'(idx);
    x.point_offset = offset;
    x.last_point = last;
    send_item(x);
  endtask

  task automatic send_timed(logic [1:0] mode, logic [31:0] t);
    in_item_t x;
    x = random_item();
    x.mode = mode;
    x.event_time = t;
    send_item(x);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    item_valid = 1'b0;
    while (expected_positions.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_seed(int j, logic [31:0] v);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = 4'(4 * j); pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    pwrite = 1'b0; penable = 1'b0;
    seed_val[j] = v;
    start_pos[j] = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata !== v) begin
      $display("%0t seed %0d read back: expected %h, actual %h", $time, j, v, prdata);
      errors++;
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  task automatic write_all_seeds(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                 logic [31:0] d);
    write_seed(0, a);
    write_seed(1, b);
    write_seed(2, c);
    write_seed(3, d);
  endtask

  // Loads n waypoints in slot order, commits them and queries around the new trajectory.
  task automatic run_trajectory(int n, bit unordered, int queries);
    logic [31:0] t;
    logic [31:0] ct;
    int r;
    t = 0;
    for (int i = 0; i < n; i++) begin
      t = t + (($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 600));
      send_load(i, unordered ? $urandom_range(0, 3000) : t, i == n - 1);
    end
    ct = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 5000);
    send_timed(MODE_COMMIT, ct);
    for (int q = 0; q < queries; q++) begin
      r = $urandom_range(0, 9);
      if (r == 0) send_timed(MODE_QUERY, $urandom);
      else if (r == 1) send_timed(MODE_QUERY, ct - $urandom_range(1, 50));
      else if (unordered) send_timed(MODE_QUERY, ct + $urandom_range(0, 3100));
      else send_timed(MODE_QUERY, ct + $urandom_range(0, t + 20));
    end
  endtask

  task automatic test_empty_table();
    send_timed(MODE_QUERY, 32'd0);
    send_timed(MODE_QUERY, 32'hFFFF_FFFF);
    send_timed(MODE_COMMIT, 32'd100);
    send_timed(MODE_QUERY, 32'd50);
    send_timed(MODE_QUERY, 32'd200);
    wait_idle();
  endtask

  task automatic test_seed_extremes();
    write_all_seeds(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000);
    send_timed(MODE_QUERY, 32'd7);
    wait_idle();
  endtask

  task automatic test_directed_segments();
    in_item_t x;
    x = random_item();
    x.mode = MODE_LOAD; x.point_index = 0; x.point_offset = 32'd10; x.last_point = 1'b0;
    x.point_joint0 = 32'h7FFF_FFFF; x.point_joint1 = 32'h8000_0000;
    x.point_joint2 = 32'h0; x.point_joint3 = 32'hFFFF_0000;
    send_item(x);
    x.point_index = 1; x.point_offset = 32'd1000;
    x.point_joint0 = 32'h8000_0000; x.point_joint1 = 32'h7FFF_FFFF;
    send_item(x);
    x.point_index = 2; x.point_offset = 32'hFFFF_FFF0; x.last_point = 1'b1;
    send_item(x);
    send_timed(MODE_COMMIT, 32'd1000);
    send_timed(MODE_QUERY, 32'd999);
    send_timed(MODE_QUERY, 32'd1000);
    send_timed(MODE_QUERY, 32'd1005);
    send_timed(MODE_QUERY, 32'd1010);
    send_timed(MODE_QUERY, 32'd1999);
    send_timed(MODE_QUERY, 32'hFFFF_FFFF);
    send_timed(MODE_QUERY, 32'd1000 + 32'hFFFF_FFEF);
    send_timed(MODE_QUERY, 32'd1000 + 32'hFFFF_FFF0);
    x = random_item();
    x.mode = 2'd3;
    send_item(x);
    send_load(63, 32'd5, 1'b0);
    send_load(1, 32'd2, 1'b1);
    send_timed(MODE_COMMIT, 32'd1500);
    send_timed(MODE_QUERY, 32'd1501);
    send_timed(MODE_QUERY, 32'd1503);
    send_timed(MODE_QUERY, 32'd0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    in_item_t x;
    int r;
    int phase;
    phase = 0;
    while (items_sent < 620) begin
      r = $urandom_range(0, 19);
      if (r < 14) run_trajectory($urandom_range(1, 6), 1'b0, $urandom_range(1, 6));
      else if (r < 16) run_trajectory($urandom_range(2, 8), 1'b1, $urandom_range(2, 6));
      else if (r == 16 && $urandom_range(0, 3) == 0) run_trajectory(NPTS, 1'b0, 4);
      else begin
        x = random_item();
        if (x.mode == MODE_LOAD && x.last_point && !prefix_written(int'(x.point_index)))
          x.last_point = 1'b0;
        send_item(x);
      end
      if (items_sent / 180 != phase) begin
        phase = items_sent / 180;
        no_gaps = (phase % 2 == 1);
        wait_idle();
        write_all_seeds($urandom, $urandom, $urandom, $urandom);
      end
    end
    no_gaps = 1'b0;
    wait_idle();
  endtask

  task automatic test_output_stall();
    run_trajectory(3, 1'b0, 1);
    wait_idle();
    long_hold = 1'b1;
    no_gaps = 1'b1;
    for (int i = 0; i < 30; i++) send_timed(MODE_QUERY, start_t + $urandom_range(0, 2000));
    no_gaps = 1'b0;
    wait_idle();
    write_all_seeds(32'h0, 32'h0, 32'h0, 32'h0);
    send_timed(MODE_QUERY, start_t - 32'd1);
    wait_idle();
  endtask

  always begin
    int n;
    @(negedge clk);
    if (long_hold) begin
      result_ready = 1'b0;
      repeat (3000) @(negedge clk);
      long_hold = 1'b0;
    end
    n = no_gaps ? 0 : $urandom_range(0, 6);
    if (n > 0) begin
      result_ready = 1'b0;
      repeat (n) @(negedge clk);
    end
    result_ready = 1'b1;
    do @(posedge clk); while (!result_valid);
  end

  always @(posedge clk) begin
    out_item_t e;
    if (!rst && result_valid && result_ready) begin
      if (expected_positions.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, result);
        errors++;
      end else begin
        e = expected_positions.pop_front();
        queries_checked++;
        if (result.out_joint0 !== e.out_joint0 || result.out_joint1 !== e.out_joint1 ||
            result.out_joint2 !== e.out_joint2 || result.out_joint3 !== e.out_joint3 ||
            result.region !== e.region) begin
          $display("%0t mismatch: expected %h %h %h %h r%0d, actual %h %h %h %h r%0d", $time,
                   e.out_joint0, e.out_joint1, e.out_joint2, e.out_joint3, e.region,
                   result.out_joint0, result.out_joint1, result.out_joint2,
                   result.out_joint3, result.region);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NPTS; i++) begin
      shadow_time[i] = '0; active_time[i] = '0; slot_written[i] = 1'b0;
      shadow_pos[i] = '{default: '0}; active_pos[i] = '{default: '0};
    end
    shadow_cnt = 0; active_cnt = 0; start_t = '0;
    start_pos = '{default: '0}; seed_val = '{default: '0};
    repeat (5) @(negedge clk);
    rst = 1'b0;
    repeat (2) @(negedge clk);
    test_empty_table();
    test_seed_extremes();
    test_directed_segments();
    test_random_traffic();
    test_output_stall();
    if (expected_positions.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, expected_positions.size());
      errors++;
    end
    $display("Sent %0d items: %0d loads, %0d commits; %0d query results checked.",
             items_sent, loads_sent, commits_sent, queries_checked);
    $display("Seed writes, empty and full tables, unordered times and a long output stall.");
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
